/* sv/ssi_pkg.sv */
// Shared types and constants for the sorted set intersection block.
// Used by ssi_ctrl, ssi_datapath, sorted_set_intersection and ssi_checker.
`default_nettype none

package ssi_pkg;

    localparam int unsigned LIST_DEPTH_DEFAULT = 32;
    localparam int unsigned VALUE_W            = 32;
    localparam int unsigned MODE_W             = 2;

    // Request modes
    localparam logic [MODE_W-1:0] MODE_LOAD_A = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LOAD_B = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RUN    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_CMP,
        ST_SKIPA_CHK,
        ST_SKIPA_CMP,
        ST_SKIPB_CHK,
        ST_SKIPB_CMP,
        ST_FINISH
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_a;   // append request value to list A
        logic load_b;   // append request value to list B
        logic start;    // clear both read pointers
        logic ia_inc;
        logic ib_inc;
        logic take;     // new match: push pending result, hold new one
        logic finish;   // flush pending result with last mark, clear counts
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic a_more;   // ia < count_a
        logic b_more;   // ib < count_b
        logic eq;       // A head equals B head
        logic b_lt;     // B head below A head, signed
        logic a_dup;    // A head equals last match
        logic b_dup;    // B head equals last match
        logic can_take; // room to accept a new match
        logic res_free; // result register free this cycle
    } status_t;

endpackage

`default_nettype wire

/* sv/sorted_set_intersection.sv */
// Top level of the sorted set intersection block.
// Depends on ssi_pkg, ssi_ctrl and ssi_datapath.
//
// Each request carries a mode and a value. A load request (list A or list B)
// appends the signed value to that list and leaves the block ready for further
// requests; a load into a full list (LIST_DEPTH entries) is dropped. A run
// request merges the two lists with two read pointers and returns every
// distinct value common to both, ascending, the final one with is_last set.
// An empty intersection gives a single result with none_found and is_last set
// and common_value zero. The run then empties both lists. Mode 3 is accepted
// and ignored. Every pointer step of a run waits on a registered read of the
// list stores, and each common value also passes through the check that ends
// the B repeat skip. A run also waits whenever the result side holds off. New
// requests are taken only between runs; the last result of a run may still
// be waiting while the next loads come in.
`default_nettype none

module sorted_set_intersection
#(
    parameter int unsigned LIST_DEPTH = ssi_pkg::LIST_DEPTH_DEFAULT
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // request channel
    input  wire logic                               req_valid,
    output logic                                    req_ready,
    input  wire logic [ssi_pkg::MODE_W-1:0]         mode,
    input  wire logic signed [ssi_pkg::VALUE_W-1:0] value,
    // result channel
    output logic                                    res_valid,
    input  wire logic                               res_ready,
    output logic signed [ssi_pkg::VALUE_W-1:0]      common_value,
    output logic                                    is_last,
    output logic                                    none_found
);

    ssi_pkg::cmd_t    cmd;
    ssi_pkg::status_t status;

    // Sequencer: load handling and the merge walk
    ssi_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .mode      (mode),
        .req_ready (req_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Stores, pointers, pending match and the result register
    ssi_datapath
    #(
        .LIST_DEPTH (LIST_DEPTH)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .value        (value),
        .cmd          (cmd),
        .status       (status),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .common_value (common_value),
        .is_last      (is_last),
        .none_found   (none_found)
    );

endmodule

`default_nettype wire

/* sv/ssi_ctrl.sv */
// Merge controller for the sorted set intersection block.
// Depends on ssi_pkg (state_t, cmd_t, status_t, mode codes).
`default_nettype none

module ssi_ctrl
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        req_valid,
    input  wire logic [ssi_pkg::MODE_W-1:0]  mode,
    output logic                             req_ready,
    input  wire ssi_pkg::status_t            status,
    output ssi_pkg::cmd_t                    cmd
);

    ssi_pkg::state_t state_reg;
    ssi_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ssi_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ssi_pkg::ST_IDLE:
            begin
                if (req_valid && (mode == ssi_pkg::MODE_RUN))
                begin
                    state_next = ssi_pkg::ST_CHECK;
                end
            end
            ssi_pkg::ST_CHECK:
            begin
                state_next = (status.a_more && status.b_more) ? ssi_pkg::ST_CMP
                                                              : ssi_pkg::ST_FINISH;
            end
            ssi_pkg::ST_CMP:
            begin
                if (status.eq)
                begin
                    state_next = status.can_take ? ssi_pkg::ST_SKIPA_CHK : ssi_pkg::ST_CMP;
                end
                else
                begin
                    state_next = ssi_pkg::ST_CHECK;
                end
            end
            ssi_pkg::ST_SKIPA_CHK:
            begin
                state_next = status.a_more ? ssi_pkg::ST_SKIPA_CMP : ssi_pkg::ST_CHECK;
            end
            ssi_pkg::ST_SKIPA_CMP:
            begin
                state_next = status.a_dup ? ssi_pkg::ST_SKIPA_CHK : ssi_pkg::ST_SKIPB_CHK;
            end
            ssi_pkg::ST_SKIPB_CHK:
            begin
                state_next = status.b_more ? ssi_pkg::ST_SKIPB_CMP : ssi_pkg::ST_CHECK;
            end
            ssi_pkg::ST_SKIPB_CMP:
            begin
                state_next = status.b_dup ? ssi_pkg::ST_SKIPB_CHK : ssi_pkg::ST_CHECK;
            end
            ssi_pkg::ST_FINISH:
            begin
                if (status.res_free)
                begin
                    state_next = ssi_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = ssi_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd       = '0;
        req_ready = 1'b0;
        case (state_reg)
            ssi_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load_a = (mode == ssi_pkg::MODE_LOAD_A);
                    cmd.load_b = (mode == ssi_pkg::MODE_LOAD_B);
                    cmd.start  = (mode == ssi_pkg::MODE_RUN);
                end
            end
            ssi_pkg::ST_CMP:
            begin
                if (status.eq)
                begin
                    cmd.take   = status.can_take;
                    cmd.ia_inc = status.can_take;
                end
                else if (status.b_lt)
                begin
                    cmd.ib_inc = 1'b1;
                end
                else
                begin
                    cmd.ia_inc = 1'b1;
                end
            end
            ssi_pkg::ST_SKIPA_CMP:
            begin
                // leaving the A repeats means A is not exhausted: step B too
                cmd.ia_inc = status.a_dup;
                cmd.ib_inc = !status.a_dup;
            end
            ssi_pkg::ST_SKIPB_CMP:
            begin
                cmd.ib_inc = status.b_dup;
            end
            ssi_pkg::ST_FINISH:
            begin
                cmd.finish = status.res_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* sv/ssi_datapath.sv */
// List stores, pointers and result registers of the sorted set intersection.
// Depends on ssi_pkg (cmd_t, status_t, widths).
`default_nettype none

module ssi_datapath
#(
    parameter int unsigned LIST_DEPTH = ssi_pkg::LIST_DEPTH_DEFAULT
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic signed [ssi_pkg::VALUE_W-1:0] value,
    input  wire ssi_pkg::cmd_t                      cmd,
    output ssi_pkg::status_t                        status,
    output logic                                    res_valid,
    input  wire logic                               res_ready,
    output logic signed [ssi_pkg::VALUE_W-1:0]      common_value,
    output logic                                    is_last,
    output logic                                    none_found
);

    localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
    localparam int unsigned AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam logic [CW-1:0] DEPTH_C = CW'(LIST_DEPTH);

    logic [ssi_pkg::VALUE_W-1:0] mem_a [LIST_DEPTH];
    logic [ssi_pkg::VALUE_W-1:0] mem_b [LIST_DEPTH];
    logic [ssi_pkg::VALUE_W-1:0] rd_a_reg;
    logic [ssi_pkg::VALUE_W-1:0] rd_b_reg;

    logic [CW-1:0] count_a_reg, count_a_next;
    logic [CW-1:0] count_b_reg, count_b_next;
    logic [CW-1:0] ia_reg, ia_next;
    logic [CW-1:0] ib_reg, ib_next;

    logic                        pend_valid_reg, pend_valid_next;
    logic [ssi_pkg::VALUE_W-1:0] pend_value_reg, pend_value_next;

    logic                        res_valid_reg, res_valid_next;
    logic [ssi_pkg::VALUE_W-1:0] res_value_reg, res_value_next;
    logic                        res_last_reg, res_last_next;
    logic                        res_none_reg, res_none_next;

    logic a_room;
    logic b_room;
    logic res_free;

    assign a_room   = (count_a_reg < DEPTH_C);
    assign b_room   = (count_b_reg < DEPTH_C);
    assign res_free = !res_valid_reg || res_ready;

    // Stores: one write, one registered read each
    always_ff @(posedge clk)
    begin
        if (cmd.load_a && a_room)
        begin
            mem_a[count_a_reg[AW-1:0]] <= value;
        end
        rd_a_reg <= mem_a[ia_reg[AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_b && b_room)
        begin
            mem_b[count_b_reg[AW-1:0]] <= value;
        end
        rd_b_reg <= mem_b[ib_reg[AW-1:0]];
    end

    always_comb
    begin
        count_a_next = count_a_reg;
        count_b_next = count_b_reg;
        if (cmd.finish)
        begin
            count_a_next = '0;
            count_b_next = '0;
        end
        else
        begin
            if (cmd.load_a && a_room)
            begin
                count_a_next = count_a_reg + CW'(1);
            end
            if (cmd.load_b && b_room)
            begin
                count_b_next = count_b_reg + CW'(1);
            end
        end

        ia_next = ia_reg;
        ib_next = ib_reg;
        if (cmd.start)
        begin
            ia_next = '0;
            ib_next = '0;
        end
        else
        begin
            if (cmd.ia_inc)
            begin
                ia_next = ia_reg + CW'(1);
            end
            if (cmd.ib_inc)
            begin
                ib_next = ib_reg + CW'(1);
            end
        end
    end

    // Pending match and result register
    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_value_next = pend_value_reg;
        res_valid_next  = res_valid_reg && !res_ready;
        res_value_next  = res_value_reg;
        res_last_next   = res_last_reg;
        res_none_next   = res_none_reg;

        if (cmd.take)
        begin
            if (pend_valid_reg)
            begin
                res_valid_next = 1'b1;
                res_value_next = pend_value_reg;
                res_last_next  = 1'b0;
                res_none_next  = 1'b0;
            end
            pend_valid_next = 1'b1;
            pend_value_next = rd_a_reg;
        end
        else if (cmd.finish)
        begin
            res_valid_next  = 1'b1;
            res_value_next  = pend_valid_reg ? pend_value_reg : '0;
            res_last_next   = 1'b1;
            res_none_next   = !pend_valid_reg;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_a_reg    <= '0;
            count_b_reg    <= '0;
            ia_reg         <= '0;
            ib_reg         <= '0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            count_a_reg    <= count_a_next;
            count_b_reg    <= count_b_next;
            ia_reg         <= ia_next;
            ib_reg         <= ib_next;
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_value_reg <= pend_value_next;
        res_value_reg  <= res_value_next;
        res_last_reg   <= res_last_next;
        res_none_reg   <= res_none_next;
    end

    always_comb
    begin
        status.a_more   = (ia_reg < count_a_reg);
        status.b_more   = (ib_reg < count_b_reg);
        status.eq       = (rd_a_reg == rd_b_reg);
        status.b_lt     = ($signed(rd_b_reg) < $signed(rd_a_reg));
        status.a_dup    = (rd_a_reg == pend_value_reg);
        status.b_dup    = (rd_b_reg == pend_value_reg);
        status.can_take = !pend_valid_reg || res_free;
        status.res_free = res_free;
    end

    assign res_valid    = res_valid_reg;
    assign common_value = res_value_reg;
    assign is_last      = res_last_reg;
    assign none_found   = res_none_reg;

endmodule

`default_nettype wire

/* sv/ssi_checker.sv */
// Port-level checks for sorted_set_intersection, attached by bind.
// Depends on ssi_pkg (mode codes, widths).
`default_nettype none

module ssi_port_checker
(
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               req_valid,
    input wire logic                               req_ready,
    input wire logic [ssi_pkg::MODE_W-1:0]         mode,
    input wire logic                               res_valid,
    input wire logic                               res_ready,
    input wire logic signed [ssi_pkg::VALUE_W-1:0] common_value,
    input wire logic                               is_last,
    input wire logic                               none_found
);

    // An empty result is always the last of its run
    a_none_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && none_found) |-> is_last)
    else $error("none_found result without is_last");

    // An empty result carries a zero value
    a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && none_found) |-> (common_value == '0))
    else $error("none_found result with nonzero value");

    // A run keeps the request side busy for at least the next cycle
    a_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready && (mode == ssi_pkg::MODE_RUN)) |=> !req_ready)
    else $error("request taken right after a run request");

    // A stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_ready) |=>
            (res_valid && $stable(common_value) && $stable(is_last) && $stable(none_found)))
    else $error("result changed while stalled");

endmodule

bind sorted_set_intersection ssi_port_checker u_ssi_port_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req_valid),
    .req_ready    (req_ready),
    .mode         (mode),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .common_value (common_value),
    .is_last      (is_last),
    .none_found   (none_found)
);

`default_nettype wire
